FILE: design/slt_pkg.sv
package slt_pkg;

	localparam int POS_WIDTH_DEF = 16;
	localparam int TOK_W = 16;
	localparam int CHAR_W = 8;
	localparam int WORD_W = 32;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [TOK_W-1:0] LEN_MAX = '1;
	localparam logic [WORD_W-1:0] WORD_DRIM = 32'h6472696D;
	localparam logic [WORD_W-1:0] WORD_WAKE = 32'h77616B65;

	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_NL = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_EQ = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_LP = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RP = 8'h29;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

	typedef enum logic [3:0] {
		KIND_EOF = 4'd0,
		KIND_INT = 4'd1,
		KIND_ID = 4'd2,
		KIND_ASSIGN = 4'd3,
		KIND_LPAREN = 4'd4,
		KIND_RPAREN = 4'd5,
		KIND_DRIM = 4'd6,
		KIND_WAKE = 4'd7,
		KIND_ERROR = 4'd8
	} kind_t;

	typedef enum logic [5:0] {
		MODE_IDLE = 6'b000001,
		MODE_INT = 6'b000010,
		MODE_IDENT = 6'b000100,
		MODE_SLASH = 6'b001000,
		MODE_COMMENT = 6'b010000,
		MODE_HALT = 6'b100000
	} mode_t;

	typedef struct packed {
		kind_t kind;
		logic [TOK_W-1:0] start;
		logic [TOK_W-1:0] length;
		logic [CHAR_W-1:0] bad;
		logic last;
	} tok_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

FILE: design/slt_in_if.sv
interface slt_in_if import slt_pkg::*; ();
	logic valid;
	logic ready;
	logic [CHAR_W-1:0] char_code;
	logic end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

FILE: design/slt_out_if.sv
interface slt_out_if import slt_pkg::*; ();
	logic valid;
	logic ready;
	logic [3:0] token_kind;
	logic [TOK_W-1:0] token_start;
	logic [TOK_W-1:0] token_length;
	logic [CHAR_W-1:0] bad_char;
	logic last_of_run;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output bad_char, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_start,
		input token_length, input bad_char, input last_of_run, output ready);
endinterface

FILE: design/small_language_tokenizer.sv
// throughput: one byte per cycle while text.ready is high; a byte closing a token
// that is itself a one-byte token or an error gives two tokens, which leave one per
// cycle while tokens.ready is high through a four-entry token queue
// text.ready falls while fewer than two queue entries are free
// reset (arst_n low, asynchronous) clears scan mode, position and the queue
module small_language_tokenizer import slt_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	slt_in_if.sink text,
	slt_out_if.source tokens
);

	localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

	mode_t mode_q, mode_d;
	logic [POS_WIDTH-1:0] position_q, position_d;
	logic [TOK_W-1:0] pend_start_q, pend_start_d;
	logic [TOK_W-1:0] pend_len_q, pend_len_d;
	logic [WORD_W-1:0] lead_q, lead_d;

	tok_t fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic [CHAR_W-1:0] c;
	logic fin, take, pop;
	logic [31:0] pos_wide;
	logic [TOK_W-1:0] p16;
	kind_t word_kind;
	tok_t pend_tok, eof_tok, slash_err, r0, r1;
	logic [1:0] n;

	mode_t idle_mode;
	logic idle_emit, idle_pend, idle_lead;
	tok_t idle_tok;

	assign c = text.char_code;
	assign fin = text.end_of_text || c == '0;
	assign take = text.valid && text.ready;
	assign pop = tokens.valid && tokens.ready;
	assign text.ready = count_q <= CNT_W'(FIFO_DEPTH - 2);

	assign pos_wide = 32'(position_q);
	assign p16 = (pos_wide > 32'(LEN_MAX)) ? LEN_MAX : pos_wide[TOK_W-1:0];

	always_comb begin
		word_kind = KIND_ID;
		if (pend_len_q == TOK_W'(4) && lead_q == WORD_DRIM) word_kind = KIND_DRIM;
		else if (pend_len_q == TOK_W'(4) && lead_q == WORD_WAKE) word_kind = KIND_WAKE;
	end

	assign pend_tok = tok_t'{(mode_q == MODE_INT) ? KIND_INT : word_kind,
		pend_start_q, pend_len_q, '0, 1'b0};
	assign eof_tok = tok_t'{KIND_EOF, p16, '0, '0, 1'b0};
	assign slash_err = tok_t'{KIND_ERROR, pend_start_q, TOK_W'(1), CH_SLASH, 1'b0};

	// byte seen by a scanner that sits between tokens
	always_comb begin
		idle_mode = MODE_IDLE;
		idle_emit = 1'b0;
		idle_pend = 1'b0;
		idle_lead = 1'b0;
		idle_tok = tok_t'{KIND_ERROR, p16, TOK_W'(1), c, 1'b0};
		if (is_space(c)) begin
			idle_mode = MODE_IDLE;
		end else if (c == CH_SLASH) begin
			idle_mode = MODE_SLASH;
			idle_pend = 1'b1;
		end else if (is_digit(c)) begin
			idle_mode = MODE_INT;
			idle_pend = 1'b1;
			idle_lead = 1'b1;
		end else if (is_alpha(c)) begin
			idle_mode = MODE_IDENT;
			idle_pend = 1'b1;
			idle_lead = 1'b1;
		end else if (c == CH_EQ) begin
			idle_emit = 1'b1;
			idle_tok = tok_t'{KIND_ASSIGN, p16, TOK_W'(1), '0, 1'b0};
		end else if (c == CH_LP) begin
			idle_emit = 1'b1;
			idle_tok = tok_t'{KIND_LPAREN, p16, TOK_W'(1), '0, 1'b0};
		end else if (c == CH_RP) begin
			idle_emit = 1'b1;
			idle_tok = tok_t'{KIND_RPAREN, p16, TOK_W'(1), '0, 1'b0};
		end else begin
			idle_emit = 1'b1;
			idle_mode = MODE_HALT;
		end
	end

	always_comb begin
		mode_d = mode_q;
		position_d = position_q;
		pend_start_d = pend_start_q;
		pend_len_d = pend_len_q;
		lead_d = lead_q;
		n = 2'd0;
		r0 = eof_tok;
		r1 = eof_tok;
		if (take && mode_q != MODE_HALT) begin
			if (fin) begin
				mode_d = MODE_HALT;
				if (mode_q == MODE_INT || mode_q == MODE_IDENT) begin
					r0 = pend_tok;
					n = 2'd2;
				end else if (mode_q == MODE_SLASH) begin
					r0 = slash_err;
					n = 2'd1;
				end else begin
					n = 2'd1;
				end
			end else begin
				position_d = (position_q == POS_MAX) ? position_q : position_q + 1'b1;
				case (mode_q)
					MODE_INT, MODE_IDENT: begin
						if (is_digit(c) || (mode_q == MODE_IDENT && is_alpha(c))) begin
							if (pend_len_q < TOK_W'(4)) lead_d = {lead_q[WORD_W-CHAR_W-1:0], c};
							if (pend_len_q != LEN_MAX) pend_len_d = pend_len_q + 1'b1;
						end else begin
							// close the token, then treat the byte as if between tokens
							r0 = pend_tok;
							r1 = idle_tok;
							n = idle_emit ? 2'd2 : 2'd1;
							mode_d = idle_mode;
							if (idle_pend) begin
								pend_start_d = p16;
								pend_len_d = TOK_W'(1);
							end
							if (idle_lead) lead_d = WORD_W'(c);
						end
					end
					MODE_SLASH: begin
						if (c == CH_SLASH) begin
							mode_d = MODE_COMMENT;
						end else begin
							r0 = slash_err;
							n = 2'd1;
							mode_d = MODE_HALT;
						end
					end
					MODE_COMMENT: begin
						if (c == CH_NL) mode_d = MODE_IDLE;
					end
					default: begin
						r0 = idle_tok;
						n = idle_emit ? 2'd1 : 2'd0;
						mode_d = idle_mode;
						if (idle_pend) begin
							pend_start_d = p16;
							pend_len_d = TOK_W'(1);
						end
						if (idle_lead) lead_d = WORD_W'(c);
					end
				endcase
			end
		end
		r0.last = (n == 2'd1);
		r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			position_q <= '0;
			pend_start_q <= '0;
			pend_len_q <= '0;
			lead_q <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			mode_q <= mode_d;
			position_q <= position_d;
			pend_start_q <= pend_start_d;
			pend_len_q <= pend_len_d;
			lead_q <= lead_d;
			wr_ptr_q <= wr_ptr_q + PTR_W'(n);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + CNT_W'(n) - CNT_W'(pop);
		end
	end

	// token queue payload
	always_ff @(posedge clk) begin
		if (n != 2'd0) fifo_q[wr_ptr_q] <= r0;
		if (n == 2'd2) fifo_q[wr_ptr_q + PTR_W'(1)] <= r1;
	end

	assign tokens.valid = count_q != '0;
	assign tokens.token_kind = fifo_q[rd_ptr_q].kind;
	assign tokens.token_start = fifo_q[rd_ptr_q].start;
	assign tokens.token_length = fifo_q[rd_ptr_q].length;
	assign tokens.bad_char = fifo_q[rd_ptr_q].bad;
	assign tokens.last_of_run = fifo_q[rd_ptr_q].last;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top import slt_pkg::*; ();

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int STALL_CYCLES = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_WORD_LEN = 100;

	logic clk;
	logic arst_n;

	slt_in_if text_if ();
	slt_out_if tok_if ();

	small_language_tokenizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_if),
		.tokens(tok_if)
	);

	// scanner state mirrored from the accepted text
	mode_t scan_mode;
	logic [POS_WIDTH_DEF-1:0] scan_pos;
	logic [TOK_W-1:0] word_start;
	logic [TOK_W-1:0] word_len;
	logic [WORD_W-1:0] word_head;

	tok_t due_tokens[$];
	int mismatch_count;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_ticket;
	int stall_seen;
	int stall_left;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic digit_byte(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic letter_byte(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic blank_byte(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic tok_t make_token(input kind_t k, input logic [TOK_W-1:0] s,
			input logic [TOK_W-1:0] l, input logic [7:0] b);
		tok_t t;
		t.kind = k;
		t.start = s;
		t.length = l;
		t.bad = b;
		t.last = 1'b0;
		return t;
	endfunction

	function automatic kind_t word_kind();
		if (word_len == 4 && word_head == WORD_DRIM)
			return KIND_DRIM;
		if (word_len == 4 && word_head == WORD_WAKE)
			return KIND_WAKE;
		return KIND_ID;
	endfunction

	// advances the mirrored scanner by one transfer and queues the tokens it yields
	function automatic void scan_byte(input logic [7:0] c, input logic eot);
		tok_t res[2];
		int n;
		logic [POS_WIDTH_DEF-1:0] p;
		logic fresh;
		n = 0;
		p = scan_pos;
		fresh = 1'b0;
		if (scan_mode == MODE_HALT)
			return;
		if (eot || c == 8'd0) begin
			case (scan_mode)
				MODE_INT: begin
					res[n] = make_token(KIND_INT, word_start, word_len, 8'd0);
					n++;
				end
				MODE_IDENT: begin
					res[n] = make_token(word_kind(), word_start, word_len, 8'd0);
					n++;
				end
				MODE_SLASH: begin
					res[n] = make_token(KIND_ERROR, word_start, 16'd1, CH_SLASH);
					n++;
				end
				default: ;
			endcase
			if (scan_mode != MODE_SLASH) begin
				res[n] = make_token(KIND_EOF, p, 16'd0, 8'd0);
				n++;
			end
			scan_mode = MODE_HALT;
		end else begin
			if (scan_pos != '1)
				scan_pos++;
			case (scan_mode)
				MODE_INT, MODE_IDENT: begin
					if (digit_byte(c) || (scan_mode == MODE_IDENT && letter_byte(c))) begin
						if (word_len < 4)
							word_head = {word_head[WORD_W-9:0], c};
						if (word_len != LEN_MAX)
							word_len++;
					end else begin
						res[n] = make_token(scan_mode == MODE_INT ? KIND_INT : word_kind(),
							word_start, word_len, 8'd0);
						n++;
						fresh = 1'b1;
					end
				end
				MODE_SLASH: begin
					if (c == CH_SLASH) begin
						scan_mode = MODE_COMMENT;
					end else begin
						res[n] = make_token(KIND_ERROR, word_start, 16'd1, CH_SLASH);
						n++;
						scan_mode = MODE_HALT;
					end
				end
				MODE_COMMENT: begin
					if (c == CH_NL)
						scan_mode = MODE_IDLE;
				end
				default: fresh = 1'b1;
			endcase
			// byte that starts from an idle scanner, possibly right after a closed token
			if (fresh) begin
				scan_mode = MODE_IDLE;
				if (blank_byte(c)) begin
				end else if (c == CH_SLASH) begin
					scan_mode = MODE_SLASH;
					word_start = p;
					word_len = 16'd1;
				end else if (digit_byte(c) || letter_byte(c)) begin
					scan_mode = digit_byte(c) ? MODE_INT : MODE_IDENT;
					word_start = p;
					word_len = 16'd1;
					word_head = {24'd0, c};
				end else if (c == CH_EQ) begin
					res[n] = make_token(KIND_ASSIGN, p, 16'd1, 8'd0);
					n++;
				end else if (c == CH_LP) begin
					res[n] = make_token(KIND_LPAREN, p, 16'd1, 8'd0);
					n++;
				end else if (c == CH_RP) begin
					res[n] = make_token(KIND_RPAREN, p, 16'd1, 8'd0);
					n++;
				end else begin
					res[n] = make_token(KIND_ERROR, p, 16'd1, c);
					n++;
					scan_mode = MODE_HALT;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			res[i].last = (i == n - 1);
			due_tokens.push_back(res[i]);
		end
	endfunction

	// caller stands just after a rising edge; valid stays high after the transfer
	task automatic send_char(input logic [7:0] c, input logic eot);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			text_if.valid <= 1'b0;
			@(posedge clk);
		end
		text_if.valid <= 1'b1;
		text_if.char_code <= c;
		text_if.end_of_text <= eot;
		do
			@(posedge clk);
		while (!text_if.ready);
		scan_byte(c, eot);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	task automatic check_token();
		tok_t want;
		if (due_tokens.size() == 0) begin
			$error("unexpected token: kind %0d start %0d length %0d",
				tok_if.token_kind, tok_if.token_start, tok_if.token_length);
			mismatch_count++;
		end else begin
			want = due_tokens.pop_front();
			if (tok_if.token_kind !== want.kind) begin
				$error("token_kind: expected %0d, got %0d", want.kind, tok_if.token_kind);
				mismatch_count++;
			end
			if (tok_if.token_start !== want.start) begin
				$error("token_start: expected %0d, got %0d", want.start, tok_if.token_start);
				mismatch_count++;
			end
			if (tok_if.token_length !== want.length) begin
				$error("token_length: expected %0d, got %0d", want.length,
					tok_if.token_length);
				mismatch_count++;
			end
			if (tok_if.bad_char !== want.bad) begin
				$error("bad_char: expected %0d, got %0d", want.bad, tok_if.bad_char);
				mismatch_count++;
			end
			if (tok_if.last_of_run !== want.last) begin
				$error("last_of_run: expected %0d, got %0d", want.last, tok_if.last_of_run);
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			tok_if.ready <= 1'b0;
		end else begin
			if (tok_if.valid && tok_if.ready)
				check_token();
			if (stall_ticket != stall_seen) begin
				stall_seen = stall_ticket;
				stall_left = STALL_CYCLES;
			end
			if (stall_left != 0) begin
				stall_left--;
				tok_if.ready <= 1'b0;
			end else begin
				tok_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	function automatic logic [7:0] pick_letter();
		if ($urandom_range(0, 1))
			return 8'("a" + $urandom_range(0, 25));
		return 8'("A" + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] pick_alnum();
		if ($urandom_range(0, 3) == 0)
			return 8'("0" + $urandom_range(0, 9));
		return pick_letter();
	endfunction

	// one well-formed lexeme; adjacent lexemes may merge, which is still valid text
	task automatic send_lexeme();
		logic [7:0] c;
		int len;
		case ($urandom_range(0, 9))
			0, 1: begin
				len = $urandom_range(1, 6);
				repeat (len)
					send_char(8'("0" + $urandom_range(0, 9)), 1'b0);
			end
			2, 3: begin
				len = $urandom_range(0, 7);
				send_char(pick_letter(), 1'b0);
				repeat (len)
					send_char(pick_alnum(), 1'b0);
			end
			4: begin
				case ($urandom_range(0, 5))
					0: send_text("drim");
					1: send_text("wake");
					2: send_text("dri");
					3: send_text("wakes");
					4: send_text("Drim");
					default: send_text("wak3");
				endcase
			end
			5: begin
				case ($urandom_range(0, 2))
					0: send_char(CH_EQ, 1'b0);
					1: send_char(CH_LP, 1'b0);
					default: send_char(CH_RP, 1'b0);
				endcase
			end
			6: begin
				// comment body takes any byte but newline and zero
				send_char(CH_SLASH, 1'b0);
				send_char(CH_SLASH, 1'b0);
				len = $urandom_range(0, 6);
				repeat (len) begin
					do
						c = 8'($urandom_range(1, 255));
					while (c == CH_NL);
					send_char(c, 1'b0);
				end
				send_char(CH_NL, 1'b0);
			end
			default: begin
				len = $urandom_range(1, 3);
				repeat (len) begin
					if ($urandom_range(0, 2) == 0)
						send_char(CH_SPACE, 1'b0);
					else
						send_char(8'($urandom_range(9, 13)), 1'b0);
				end
			end
		endcase
	endtask

	task automatic test_directed_text();
		send_text("drim wake x=(42)\n");
		send_text("//");
		send_char(8'hFF, 1'b0);
		send_char(8'h80, 1'b0);
		send_char(CH_NL, 1'b0);
		send_char(8'h0B, 1'b0);
		send_char(8'h0C, 1'b0);
		send_char(CH_CR, 1'b0);
	endtask

	task automatic test_random_text(input int bytes);
		for (int i = 0; i < bytes; ) begin
			send_lexeme();
			i += 4;
		end
	endtask

	task automatic test_token_queue_backpressure();
		int saved_idle;
		saved_idle = send_idle_pct;
		send_idle_pct = 0;
		stall_ticket++;
		// every opening paren after a name yields two tokens, so the queue fills fast
		repeat (20) begin
			send_char(pick_letter(), 1'b0);
			send_char(CH_LP, 1'b0);
		end
		send_idle_pct = saved_idle;
	endtask

	task automatic test_long_word();
		send_char(CH_SPACE, 1'b0);
		send_text("drim");
		repeat (LONG_WORD_LEN - 4)
			send_char(pick_alnum(), 1'b0);
		send_char(CH_SPACE, 1'b0);
		send_text("q=(7)");
	endtask

	// only one way to halt per run, so the ending is chosen at random
	task automatic test_halt();
		logic [7:0] c;
		case ($urandom_range(0, 7))
			0: begin
				send_text(" abc");
				send_char(8'($urandom_range(0, 255)), 1'b1);
			end
			1: begin
				send_text(" 123");
				send_char(8'd0, 1'b0);
			end
			2: begin
				send_text(" /");
				send_char(8'($urandom_range(0, 255)), 1'b1);
			end
			3: begin
				send_text(" //xy");
				send_char(8'($urandom_range(0, 255)), 1'b1);
			end
			4: send_text(" /a");
			5: begin
				send_text(" x");
				send_char(8'($urandom_range(128, 255)), 1'b0);
			end
			6: begin
				send_char(CH_SPACE, 1'b0);
				if ($urandom_range(0, 3) == 0) begin
					c = 8'h7F;
				end else begin
					do
						c = 8'($urandom_range(1, 31));
					while (blank_byte(c));
				end
				send_char(c, 1'b0);
			end
			default: begin
				send_char(CH_SPACE, 1'b0);
				send_char(8'($urandom_range(0, 255)), 1'b1);
			end
		endcase
		// halted: nothing further may come out
		repeat (24)
			send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b0);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		text_if.valid = 1'b0;
		text_if.char_code = '0;
		text_if.end_of_text = 1'b0;
		tok_if.ready = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		stall_ticket = 0;
		stall_seen = 0;
		stall_left = 0;
		scan_mode = MODE_IDLE;
		scan_pos = '0;
		word_start = '0;
		word_len = '0;
		word_head = '0;
		send_idle_pct = 33;
		recv_idle_pct = 80;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_text();
		test_random_text(400);
		send_idle_pct = 80;
		recv_idle_pct = 33;
		test_random_text(400);
		test_token_queue_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_text(300);
		test_long_word();
		test_halt();

		text_if.valid <= 1'b0;
		while (due_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
